@@ rtl/psms_pkg.sv @@
// Package: shared types and constants for the packed special-matrix store.
package psms_pkg;

    localparam int IDX_W  = 5;
    localparam int DATA_W = 32;
    localparam int ACC_W  = 12;
    localparam int LAY_W  = 3;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    localparam logic [LAY_W-1:0] LAYOUT_SYM_ROW = 3'd0;
    localparam logic [LAY_W-1:0] LAYOUT_SYM_COL = 3'd1;
    localparam logic [LAY_W-1:0] LAYOUT_TRI_ROW = 3'd2;
    localparam logic [LAY_W-1:0] LAYOUT_TRI_COL = 3'd3;
    localparam logic [LAY_W-1:0] LAYOUT_TD_ROW  = 3'd4;
    localparam logic [LAY_W-1:0] LAYOUT_TD_COL  = 3'd5;

    typedef enum logic {
        ALU_MUL,
        ALU_ADD
    } alu_op_t;

    typedef struct packed {
        alu_op_t          op;
        logic [ACC_W-1:0] a;
        logic [ACC_W-1:0] b;
    } alu_req_t;

endpackage

@@ rtl/packed_special_matrix_store_top.sv @@
// Top level: packed special-matrix store with index sequencer.
//
// Holds one ORDER x ORDER symmetric, lower-triangular or tridiagonal matrix
// in a packed store. Each item on the s_ channel writes or reads one element
// at a 1-based (row, col); one result item per input item leaves on m_.
// The layout register is written through cfg_valid/cfg_ready/cfg_data; the
// user must write it only while the block is idle, as the block itself does
// not enforce this; cfg_ready is always high.
// Per item the sequencer steps through decode, one multiply and one add on
// the shared unit, one store access and one load of the result register,
// then presents the result. The shared arithmetic unit and the single store
// port serve one item at a time; s_tready is high only when idle.
// A stalled receiver holds the result in the output register; no new item
// is taken until it has been accepted.
// Reset (aresetn low, synchronous) returns the sequencer to idle and the
// layout to symmetric row-major; the store contents are undefined until
// written, and reading an unwritten element returns an undefined value.
// Bad indices, accesses outside the tridiagonal band and unused layout
// codes give status 1 with zero read data and leave the store untouched.
module packed_special_matrix_store_top
    import psms_pkg::*;
#(
    parameter int ORDER = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [LAY_W-1:0]  cfg_data,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [47:0]       s_tdata,   // row[4:0], col[9:5], write_data[41:10], zero fill
    input  logic              s_tuser,   // command
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata,   // read_data
    output logic              m_tuser    // status
);

    localparam int TRI_SIZE    = ORDER * (ORDER + 1) / 2;
    localparam int STORE_DEPTH = TRI_SIZE + 1;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_MUL,
        ST_ADD,
        ST_ACCESS,
        ST_LOAD,
        ST_RESP
    } state_t;

    state_t            state_reg, state_next;
    logic [LAY_W-1:0]  layout_reg, layout_next;
    logic              cmd_reg, cmd_next;
    logic [IDX_W-1:0]  row_reg, row_next;
    logic [IDX_W-1:0]  col_reg, col_next;
    logic [DATA_W-1:0] wdata_reg, wdata_next;
    logic [ACC_W-1:0]  opa_reg, opa_next;
    logic [ACC_W-1:0]  opb_reg, opb_next;
    logic [ACC_W-1:0]  off_reg, off_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic              err_reg, err_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [DATA_W-1:0] data_reg, data_next;

    alu_req_t          alu_req;
    logic [ACC_W-1:0]  alu_y;
    logic              mem_we;
    logic              mem_re;
    logic [DATA_W-1:0] mem_rdata;

    logic [ACC_W-1:0]  row_x, col_x, i_x, j_x;
    logic              lower;
    logic              range_err;
    logic              band_err;

    psms_alu u_alu (
        .req (alu_req),
        .y   (alu_y)
    );

    psms_mem #(
        .DEPTH  (STORE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (addr_reg),
        .wdata (wdata_reg),
        .rdata (mem_rdata)
    );

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = (state_reg == ST_RESP);
    assign m_tdata   = data_reg;
    assign m_tuser   = err_reg;

    assign mem_we = (state_reg == ST_ACCESS) && !err_reg && (cmd_reg == CMD_WRITE);
    assign mem_re = (state_reg == ST_ACCESS) && !err_reg && (cmd_reg == CMD_READ);

    // Index decode
    assign row_x = ACC_W'(row_reg);
    assign col_x = ACC_W'(col_reg);
    assign lower = (row_reg >= col_reg);
    assign i_x   = lower ? row_x : col_x;
    assign j_x   = lower ? col_x : row_x;
    assign range_err = (row_reg == '0) || (col_reg == '0)
                    || (row_reg > IDX_W'(ORDER)) || (col_reg > IDX_W'(ORDER));
    assign band_err  = (row_x > col_x + ACC_W'(1)) || (col_x > row_x + ACC_W'(1));

    always_comb begin
        alu_req.op = ALU_MUL;
        alu_req.a  = opa_reg;
        alu_req.b  = opb_reg;
        if (state_reg == ST_ADD) begin
            alu_req.op = ALU_ADD;
            alu_req.a  = acc_reg >> 1;
            alu_req.b  = off_reg;
        end
    end

    always_comb begin
        state_next  = state_reg;
        layout_next = (cfg_valid && cfg_ready) ? cfg_data : layout_reg;
        cmd_next    = cmd_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        wdata_next  = wdata_reg;
        opa_next    = opa_reg;
        opb_next    = opb_reg;
        off_next    = off_reg;
        acc_next    = acc_reg;
        err_next    = err_reg;
        addr_next   = addr_reg;
        data_next   = data_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd_next   = s_tuser;
                    row_next   = s_tdata[4:0];
                    col_next   = s_tdata[9:5];
                    wdata_next = s_tdata[41:10];
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                // row-major lower: i(i-1)/2 + j-1; column-major lower:
                // (j-1)(2N-j+2)/2 + i-j; tridiagonal: 4r/2 + c-3 (row-major), 4c/2 + r-3 (column-major)
                err_next = range_err;
                opa_next = '0;
                opb_next = '0;
                off_next = ACC_W'(TRI_SIZE);
                unique case (layout_reg)
                    LAYOUT_SYM_ROW: begin
                        opa_next = i_x;
                        opb_next = i_x - ACC_W'(1);
                        off_next = j_x - ACC_W'(1);
                    end
                    LAYOUT_SYM_COL: begin
                        opa_next = j_x - ACC_W'(1);
                        opb_next = ACC_W'(2 * ORDER + 2) - j_x;
                        off_next = i_x - j_x;
                    end
                    LAYOUT_TRI_ROW: begin
                        if (lower) begin
                            opa_next = i_x;
                            opb_next = i_x - ACC_W'(1);
                            off_next = j_x - ACC_W'(1);
                        end
                    end
                    LAYOUT_TRI_COL: begin
                        if (lower) begin
                            opa_next = j_x - ACC_W'(1);
                            opb_next = ACC_W'(2 * ORDER + 2) - j_x;
                            off_next = i_x - j_x;
                        end
                    end
                    LAYOUT_TD_ROW: begin
                        err_next = range_err || band_err;
                        opa_next = ACC_W'(4);
                        opb_next = row_x;
                        off_next = col_x - ACC_W'(3);
                    end
                    LAYOUT_TD_COL: begin
                        err_next = range_err || band_err;
                        opa_next = ACC_W'(4);
                        opb_next = col_x;
                        off_next = row_x - ACC_W'(3);
                    end
                    default: begin
                        err_next = 1'b1;
                    end
                endcase
                state_next = ST_MUL;
            end
            ST_MUL: begin
                acc_next   = alu_y;
                state_next = ST_ADD;
            end
            ST_ADD: begin
                err_next   = err_reg || (alu_y >= ACC_W'(STORE_DEPTH));
                addr_next  = alu_y[ADDR_W-1:0];
                state_next = ST_ACCESS;
            end
            ST_ACCESS: begin
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                data_next  = (!err_reg && (cmd_reg == CMD_READ)) ? mem_rdata : '0;
                state_next = ST_RESP;
            end
            ST_RESP: begin
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        cmd_reg   <= cmd_next;
        row_reg   <= row_next;
        col_reg   <= col_next;
        wdata_reg <= wdata_next;
        opa_reg   <= opa_next;
        opb_reg   <= opb_next;
        off_reg   <= off_next;
        acc_reg   <= acc_next;
        err_reg   <= err_next;
        addr_reg  <= addr_next;
        data_reg  <= data_next;
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            layout_reg <= LAYOUT_SYM_ROW;
        end else begin
            state_reg  <= state_next;
            layout_reg <= layout_next;
        end
    end

`ifndef ASSERT_OFF
    a_ready_excl_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !m_tvalid)
        else $error("input ready while a result is pending");

    a_err_zero_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("error result carries data");

    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !m_tvalid)
        else $error("result presented in the cycle after acceptance");

    a_no_write_on_err: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> !$past(mem_we, 2))
        else $error("store written for a failed access");
`endif

endmodule

@@ rtl/psms_alu.sv @@
// Shared multiply/add unit used by the index sequencer.
module psms_alu
    import psms_pkg::*;
(
    input  alu_req_t         req,
    output logic [ACC_W-1:0] y
);

    always_comb begin
        unique case (req.op)
            ALU_MUL: y = req.a * req.b;
            ALU_ADD: y = req.a + req.b;
            default: y = '0;
        endcase
    end

endmodule

@@ rtl/psms_mem.sv @@
// Packed element store: single port, registered read.
module psms_mem
    import psms_pkg::*;
#(
    parameter int DEPTH  = 137,
    parameter int ADDR_W = 8
) (
    input  logic              aclk,
    input  logic              we,
    input  logic              re,
    input  logic [ADDR_W-1:0] addr,
    input  logic [DATA_W-1:0] wdata,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata <= mem[addr];
        end
    end

endmodule
